// ----- design/ntt_pkg.sv -----
`timescale 1ns / 1ps
package ntt_pkg;

	localparam int unsigned MAX_LOG2 = 10;
	localparam int unsigned DEPTH    = 1 << MAX_LOG2;
	localparam int unsigned VAL_W    = 30;
	localparam int unsigned IDX_W    = MAX_LOG2;
	localparam int unsigned CNT_W    = MAX_LOG2 + 1;
	localparam int unsigned LG_W     = 4;

	localparam logic [VAL_W-1:0] PRIME = 30'd998244353;
	localparam logic [VAL_W-1:0] GEN   = 30'd3;

	localparam logic CFG_SIZE = 1'b0;
	localparam logic CFG_INV  = 1'b1;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef logic [VAL_W-1:0] val_t;
	typedef val_t tw_tab_t [MAX_LOG2];

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SW_CHK,
		ST_SW_RD1,
		ST_SW_RD2,
		ST_SW_WR1,
		ST_SW_WR2,
		ST_BF_CHK,
		ST_BF_RD1,
		ST_BF_RD2,
		ST_BF_MS,
		ST_BF_MUL,
		ST_BF_WR1,
		ST_BF_WR2,
		ST_BF_TW,
		ST_SC_CHK,
		ST_SC_RD
	} state_t;

	// Modular product by double-and-add; both operands must be below the prime.
	function automatic val_t mul_const(val_t a, val_t b);
		logic [31:0] acc;
		acc = '0;
		for (int k = VAL_W - 1; k >= 0; k--) begin
			acc = {acc[30:0], 1'b0} + (b[k] ? {2'b00, a} : 32'd0);
			if (acc >= {1'b0, PRIME, 1'b0}) begin
				acc = acc - {1'b0, PRIME, 1'b0};
			end else if (acc >= {2'b00, PRIME}) begin
				acc = acc - {2'b00, PRIME};
			end
		end
		return acc[VAL_W-1:0];
	endfunction

	// Exponentiation done at elaboration only.
	function automatic val_t pow_const(val_t base, val_t e);
		val_t acc;
		val_t sq;
		acc = VAL_W'(1);
		sq = base;
		for (int k = 0; k < VAL_W; k++) begin
			if (e[k]) begin
				acc = mul_const(acc, sq);
			end
			sq = mul_const(sq, sq);
		end
		return acc;
	endfunction

	// Stage s uses the root of unity of order 2^(s+1).
	function automatic tw_tab_t build_tw();
		tw_tab_t t;
		for (int s = 0; s < MAX_LOG2; s++) begin
			t[s] = pow_const(GEN, (PRIME - VAL_W'(1)) >> (s + 1));
		end
		return t;
	endfunction

	localparam tw_tab_t TW_TAB = build_tw();

endpackage

// ----- design/ntt_modmul.sv -----
`timescale 1ns / 1ps
module ntt_modmul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ntt_pkg::val_t op_a,
	input  ntt_pkg::val_t op_b,
	output logic          done,
	output ntt_pkg::val_t result
);
	import ntt_pkg::*;

	localparam logic [31:0] P1 = {2'b00, PRIME};
	localparam logic [31:0] P2 = {1'b0, PRIME, 1'b0};

	logic        busy_q;
	logic        done_q;
	logic [4:0]  bit_q;
	val_t        a_q;
	val_t        b_q;
	val_t        acc_q;
	logic [31:0] sum;
	val_t        acc_nx;

	// Double-and-add from the top multiplier bit; the sum stays below 3P.
	always_comb begin
		sum = {acc_q, 1'b0} + (b_q[VAL_W-1] ? {2'b00, a_q} : 32'd0);
		if (sum >= P2) begin
			acc_nx = VAL_W'(sum - P2);
		end else if (sum >= P1) begin
			acc_nx = VAL_W'(sum - P1);
		end else begin
			acc_nx = VAL_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= 5'(VAL_W);
			end else if (busy_q) begin
				bit_q <= bit_q - 5'd1;
				if (bit_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			b_q   <= {b_q[VAL_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- design/ntt_transform_unit.sv -----
`timescale 1ns / 1ps
// Radix-2 NTT modulo 998244353 over a 1024-word coefficient memory. A load word
// (tuser 0) stores a residue at its index; a read word (tuser 1) presents the
// stored residue from the registered memory read, then raises the output valid
// flag, and the next word is taken once the result has been accepted. A load
// with tlast set starts the transform over the first N = 2^size_log2 words
// (size_log2 capped at 10), during which no word is accepted. All modular
// products run through one bit-serial multiplier, and the coefficient memory
// has a single read port. The transform does the bit-reversal, then the
// butterflies (two products each), and in inverse mode another reversal plus
// the 1/N scaling.
module ntt_transform_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // index[9:0], coefficient[39:10]
	input  logic        s_tuser,   // action: 0 load, 1 read
	input  logic        s_tlast,   // last load starts the transform
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_value[29:0], zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import ntt_pkg::*;

	val_t mem [DEPTH];
	val_t rd_q;

	state_t state_q, state_d;

	logic [LG_W-1:0]  size_q;
	logic             inv_cfg_q;
	logic [LG_W-1:0]  lg_q;
	logic             inv_q;
	logic             rev_ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LG_W-1:0]  stage_q;
	logic [IDX_W-1:0] addr_a_q;
	logic [IDX_W-1:0] addr_b_q;
	val_t             x_q;
	val_t             y_q;
	val_t             w_q;
	logic             rd_pend_q;
	logic             m_tvalid_q;

	logic             in_acc;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	val_t             mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;

	logic             mul_start;
	val_t             mul_a;
	val_t             mul_b;
	logic             mul_done;
	val_t             mul_res;

	logic [IDX_W-1:0] in_idx;
	val_t             in_coef;
	val_t             in_red;
	logic [LG_W-1:0]  lg_sat;
	logic [CNT_W-1:0] n_len;
	logic [IDX_W-1:0] rev_full;
	logic [CNT_W-1:0] partner;
	logic [IDX_W-1:0] k_idx;
	logic [IDX_W-1:0] bit_s;
	logic [IDX_W-1:0] mask_s;
	logic [IDX_W-1:0] bf_a;
	logic [VAL_W:0]   add_s;
	val_t             add_v;
	val_t             sub_v;
	val_t             scale;

	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_coef = s_tdata[IDX_W +: VAL_W];
	assign in_red  = (in_coef >= PRIME) ? in_coef - PRIME : in_coef;
	assign in_acc  = s_tvalid && s_tready;
	assign lg_sat  = (size_q > LG_W'(MAX_LOG2)) ? LG_W'(MAX_LOG2) : size_q;
	assign n_len   = CNT_W'(1) << lg_q;

	always_comb begin
		for (int k = 0; k < IDX_W; k++) begin
			rev_full[k] = cnt_q[IDX_W-1-k];
		end
	end

	// Bit-reversal partner, or the mirror position for the inverse reversal.
	assign partner = rev_ph_q ? (n_len - cnt_q)
	                          : CNT_W'(rev_full >> (LG_W'(MAX_LOG2) - lg_q));

	assign k_idx  = cnt_q[IDX_W-1:0];
	assign bit_s  = IDX_W'(1) << stage_q;
	assign mask_s = bit_s - IDX_W'(1);
	assign bf_a   = (((k_idx >> stage_q) << stage_q) << 1) | (k_idx & mask_s);

	assign add_s = {1'b0, x_q} + {1'b0, y_q};
	assign add_v = (add_s >= {1'b0, PRIME}) ? VAL_W'(add_s - {1'b0, PRIME}) : VAL_W'(add_s);
	assign sub_v = (x_q >= y_q) ? x_q - y_q : VAL_W'(x_q + PRIME - y_q);

	// Inverse of 2^lg is P - (P-1)/2^lg.
	assign scale = PRIME - ((PRIME - VAL_W'(1)) >> lg_q);

	assign s_tready = (state_q == ST_IDLE) && !rd_pend_q && !m_tvalid_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, rd_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	ntt_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_a_q;
		mem_wdata = rd_q;
		mem_re    = 1'b0;
		mem_raddr = addr_a_q;
		mul_start = 1'b0;
		mul_a     = rd_q;
		mul_b     = w_q;
		case (state_q)
			ST_IDLE: begin
				mem_raddr = in_idx;
				mem_waddr = in_idx;
				mem_wdata = in_red;
				if (in_acc) begin
					if (s_tuser == ACT_LOAD) begin
						mem_we = 1'b1;
						if (s_tlast) begin
							state_d = ST_SW_CHK;
						end
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			ST_SW_CHK: begin
				if (cnt_q >= n_len) begin
					state_d = rev_ph_q ? ST_SC_CHK : ST_BF_CHK;
				end else if (cnt_q < partner) begin
					state_d = ST_SW_RD1;
				end
			end
			ST_SW_RD1: begin
				mem_re  = 1'b1;
				state_d = ST_SW_RD2;
			end
			ST_SW_RD2: begin
				mem_re    = 1'b1;
				mem_raddr = addr_b_q;
				state_d   = ST_SW_WR1;
			end
			ST_SW_WR1: begin
				mem_we  = 1'b1;
				state_d = ST_SW_WR2;
			end
			ST_SW_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = addr_b_q;
				mem_wdata = x_q;
				state_d   = ST_SW_CHK;
			end
			ST_BF_CHK: begin
				if (stage_q == lg_q) begin
					state_d = inv_q ? ST_SW_CHK : ST_IDLE;
				end else if (cnt_q != (n_len >> 1)) begin
					state_d = ST_BF_RD1;
				end
			end
			ST_BF_RD1: begin
				mem_re  = 1'b1;
				state_d = ST_BF_RD2;
			end
			ST_BF_RD2: begin
				mem_re    = 1'b1;
				mem_raddr = addr_b_q;
				state_d   = ST_BF_MS;
			end
			ST_BF_MS: begin
				mul_start = 1'b1;
				state_d   = ST_BF_MUL;
			end
			ST_BF_MUL: begin
				if (mul_done) begin
					state_d = ST_BF_WR1;
				end
			end
			ST_BF_WR1: begin
				mem_we    = 1'b1;
				mem_wdata = add_v;
				state_d   = ST_BF_WR2;
			end
			ST_BF_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = addr_b_q;
				mem_wdata = sub_v;
				mul_start = 1'b1;
				mul_a     = w_q;
				mul_b     = TW_TAB[stage_q];
				state_d   = ST_BF_TW;
			end
			ST_BF_TW: begin
				if (mul_done) begin
					state_d = ST_BF_CHK;
				end
			end
			ST_SC_CHK: begin
				if (cnt_q >= n_len) begin
					state_d = ST_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cnt_q[IDX_W-1:0];
					state_d   = ST_SC_RD;
				end
			end
			ST_SC_RD: begin
				// Waits here twice: first to start the product, then for its end.
				mul_b = scale;
				if (!rev_ph_q) begin
					mem_we    = mul_done;
					mem_wdata = mul_res;
					if (mul_done) begin
						state_d = ST_SC_CHK;
					end
				end else begin
					mul_start = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			size_q     <= LG_W'(MAX_LOG2);
			inv_cfg_q  <= 1'b0;
			lg_q       <= '0;
			inv_q      <= 1'b0;
			rev_ph_q   <= 1'b0;
			cnt_q      <= '0;
			stage_q    <= '0;
			rd_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE: size_q    <= cfg_data;
					CFG_INV:  inv_cfg_q <= cfg_data[0];
					default:  size_q    <= size_q;
				endcase
			end
			rd_pend_q <= in_acc && (s_tuser != ACT_LOAD);
			if (rd_pend_q) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == ACT_LOAD && s_tlast) begin
						lg_q     <= lg_sat;
						inv_q    <= inv_cfg_q;
						rev_ph_q <= 1'b0;
						cnt_q    <= '0;
					end
				end
				ST_SW_CHK: begin
					if (cnt_q >= n_len) begin
						cnt_q   <= '0;
						stage_q <= '0;
						// rev_ph_q doubles as the scale sub-step flag from here on.
						rev_ph_q <= 1'b1;
					end else if (!(cnt_q < partner)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SW_WR2: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_BF_CHK: begin
					if (stage_q == lg_q) begin
						cnt_q    <= CNT_W'(1);
						rev_ph_q <= 1'b1;
					end else if (cnt_q == (n_len >> 1)) begin
						stage_q <= stage_q + LG_W'(1);
						cnt_q   <= '0;
					end
				end
				ST_BF_TW: begin
					if (mul_done) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SC_RD: begin
					if (rev_ph_q) begin
						rev_ph_q <= 1'b0;
					end else if (mul_done) begin
						rev_ph_q <= 1'b1;
						cnt_q    <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SW_CHK: begin
				addr_a_q <= cnt_q[IDX_W-1:0];
				addr_b_q <= partner[IDX_W-1:0];
			end
			ST_SW_RD2: begin
				x_q <= rd_q;
			end
			ST_BF_CHK: begin
				addr_a_q <= bf_a;
				addr_b_q <= bf_a | bit_s;
				if ((k_idx & mask_s) == '0) begin
					w_q <= VAL_W'(1);
				end
			end
			ST_BF_RD2: begin
				x_q <= rd_q;
			end
			ST_BF_MUL: begin
				y_q <= mul_res;
			end
			ST_BF_TW: begin
				w_q <= mul_res;
			end
			ST_SC_CHK: begin
				addr_a_q <= cnt_q[IDX_W-1:0];
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

endmodule
